// ----- hw/rtl/rxpc_pkg.sv -----
// ----------------------------------------------------------------------------
// rxpc_pkg
// Shared types for the rolling XOR packet codec: the input item and the
// result item as they travel between the stage registers and the core.
// ----------------------------------------------------------------------------
package rxpc_pkg;

	localparam int unsigned ByteW = 8;

	typedef logic [ByteW-1:0] byte_t;

	// Action codes
	typedef enum logic {
		ACT_ENCODE = 1'b0,
		ACT_DECODE = 1'b1
	} action_t;

	// One input item
	typedef struct packed {
		action_t action;
		logic    first_byte;
		byte_t   rand_key;
		byte_t   data_byte;
		logic    last_byte;
	} item_t;

	// One result item
	typedef struct packed {
		byte_t out_byte;
		logic  out_last;
		logic  checksum_ok;
	} result_t;

endpackage

// ----- hw/rtl/rolling_xor_packet_codec.sv -----
// ----------------------------------------------------------------------------
// rolling_xor_packet_codec
// Byte-stream codec for packet bodies: two chained rolling XOR stages,
// encode or decode per item, payload checksum check on decode.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------
//  in      | in_valid / in_ready  | action, first_byte, rand_key, data_byte,
//          |                      | last_byte
//  out     | out_valid/ out_ready | out_byte, out_last, checksum_ok
//  cfg     | cfg_we (no wait)     | cfg_wdata -> packet_key
//
// One item per clock sustained while out_ready stays high. Each item is
// registered first in the input register, then in the result register.
// The chain update (8-bit adds and XORs in the core) is combinational.
// Reset clears the chain state, packet_key and both stage valids.
// When out_ready is low the result holds and the input register fills;
// in_ready drops only when both stages are full.
// ----------------------------------------------------------------------------
module rolling_xor_packet_codec (
	input  logic       clk,
	input  logic       arst_n,
	// input channel
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic       first_byte,
	input  logic [7:0] rand_key,
	input  logic [7:0] data_byte,
	input  logic       last_byte,
	// result channel
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       checksum_ok,
	// configuration
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	rxpc_pkg::byte_t   packet_key_q;
	rxpc_pkg::item_t   item_s1;
	logic              valid_s1;
	rxpc_pkg::result_t res_s2;
	logic              valid_s2;
	rxpc_pkg::result_t res_nxt;
	logic              adv_s1;
	logic              take_in;

	// stage control
	assign adv_s1   = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || adv_s1;
	assign take_in  = in_valid && in_ready;

	// key register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			packet_key_q <= '0;
		end else if (cfg_we) begin
			packet_key_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1.action     <= rxpc_pkg::action_t'(action);
			item_s1.first_byte <= first_byte;
			item_s1.rand_key   <= rand_key;
			item_s1.data_byte  <= data_byte;
			item_s1.last_byte  <= last_byte;
		end
	end

	rxpc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (adv_s1),
		.packet_key (packet_key_q),
		.item       (item_s1),
		.result     (res_nxt)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!valid_s2 || out_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign out_valid   = valid_s2;
	assign out_byte    = res_s2.out_byte;
	assign out_last    = res_s2.out_last;
	assign checksum_ok = res_s2.checksum_ok;

`ifndef ASSERT_OFF
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input register empty but in_ready low");

	a_adv_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 |=> valid_s2)
		else $error("advanced item missing from result register");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !out_ready) |-> !adv_s1)
		else $error("stalled result overwritten");

	a_ok_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && checksum_ok) |-> out_last)
		else $error("checksum_ok set on a non-last item");
`endif

endmodule

// ----- hw/rtl/rxpc_core.sv -----
// ----------------------------------------------------------------------------
// rxpc_core
// Chaining core: holds the per-packet chain state and codes one item per
// advance. The result is combinational from the staged item and the state.
// ----------------------------------------------------------------------------
module rxpc_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  rxpc_pkg::byte_t  packet_key,
	input  rxpc_pkg::item_t  item,
	output rxpc_pkg::result_t result
);

	rxpc_pkg::byte_t prev_inner_q;
	rxpc_pkg::byte_t prev_outer_q;
	rxpc_pkg::byte_t byte_index_q;
	rxpc_pkg::byte_t rand_key_q;
	rxpc_pkg::byte_t checksum_q;
	rxpc_pkg::byte_t sum_q;

	rxpc_pkg::byte_t pi_cur, po_cur, idx_cur, rk_cur, sum_cur;
	rxpc_pkg::byte_t inner_mask, outer_mask;
	rxpc_pkg::byte_t plain, mid, coded;
	rxpc_pkg::byte_t sum_nxt, checksum_nxt;
	logic            decode;

	// packet start clears the chain before coding
	always_comb begin
		if (item.first_byte) begin
			pi_cur  = '0;
			po_cur  = '0;
			idx_cur = '0;
			sum_cur = '0;
			rk_cur  = item.rand_key;
		end else begin
			pi_cur  = prev_inner_q;
			po_cur  = prev_outer_q;
			idx_cur = byte_index_q;
			sum_cur = sum_q;
			rk_cur  = rand_key_q;
		end
	end

	// masks: previous value + key + index + 1, mod 256
	assign inner_mask = pi_cur + rk_cur + idx_cur + rxpc_pkg::byte_t'(1);
	assign outer_mask = po_cur + packet_key + idx_cur + rxpc_pkg::byte_t'(1);

	assign decode = (item.action == rxpc_pkg::ACT_DECODE);

	// two XOR stages, run forward or in reverse
	always_comb begin
		if (decode) begin
			coded = item.data_byte;
			mid   = coded ^ outer_mask;
			plain = mid ^ inner_mask;
		end else begin
			plain = item.data_byte;
			mid   = plain ^ inner_mask;
			coded = mid ^ outer_mask;
		end
	end

	// checksum byte is kept, payload bytes are summed
	assign checksum_nxt = item.first_byte ? plain : checksum_q;
	assign sum_nxt      = item.first_byte ? sum_cur : sum_cur + plain;

	assign result.out_byte    = decode ? plain : coded;
	assign result.out_last    = item.last_byte;
	assign result.checksum_ok = decode && item.last_byte && (sum_nxt == checksum_nxt);

	// chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_inner_q <= '0;
			prev_outer_q <= '0;
			byte_index_q <= '0;
			rand_key_q   <= '0;
			checksum_q   <= '0;
			sum_q        <= '0;
		end else if (advance) begin
			prev_inner_q <= mid;
			prev_outer_q <= coded;
			byte_index_q <= idx_cur + rxpc_pkg::byte_t'(1);
			rand_key_q   <= rk_cur;
			checksum_q   <= checksum_nxt;
			sum_q        <= sum_nxt;
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the rolling XOR packet codec against its own copy of the two-stage
// chain. Well-formed packets (encode, decode, mixed), flawed checksums, empty
// packets, index wrap and loose bytes are pushed under several key settings
// and idle/stall mixes; every result is matched in order against the chain.
// ----------------------------------------------------------------------------

// Tracks the codec chain and holds the results it owes, oldest first
class xor_chain_board;
	rxpc_pkg::byte_t   key;
	rxpc_pkg::byte_t   inner;
	rxpc_pkg::byte_t   outer;
	rxpc_pkg::byte_t   idx;
	rxpc_pkg::byte_t   rk;
	rxpc_pkg::byte_t   csum;
	rxpc_pkg::byte_t   psum;
	rxpc_pkg::result_t results_due[$];
	int                errors;

	function new();
		key    = '0;
		inner  = '0;
		outer  = '0;
		idx    = '0;
		rk     = '0;
		csum   = '0;
		psum   = '0;
		errors = 0;
	endfunction

	// Run one accepted item through the chain and queue its result
	function void absorb_byte(rxpc_pkg::item_t it);
		rxpc_pkg::byte_t   inner_mask;
		rxpc_pkg::byte_t   outer_mask;
		rxpc_pkg::byte_t   plain;
		rxpc_pkg::byte_t   mid;
		rxpc_pkg::byte_t   coded;
		rxpc_pkg::result_t r;
		if (it.first_byte) begin
			inner = '0;
			outer = '0;
			idx   = '0;
			psum  = '0;
			rk    = it.rand_key;
		end
		inner_mask = inner + rk + idx + 8'd1;
		outer_mask = outer + key + idx + 8'd1;
		if (it.action == rxpc_pkg::ACT_DECODE) begin
			coded = it.data_byte;
			mid   = coded ^ outer_mask;
			plain = mid ^ inner_mask;
			r.out_byte = plain;
		end else begin
			plain = it.data_byte;
			mid   = plain ^ inner_mask;
			coded = mid ^ outer_mask;
			r.out_byte = coded;
		end
		if (it.first_byte)
			csum = plain;
		else
			psum = psum + plain;
		r.out_last    = it.last_byte;
		r.checksum_ok = (it.action == rxpc_pkg::ACT_DECODE && it.last_byte) ?
			(psum == csum) : 1'b0;
		inner = mid;
		outer = coded;
		idx   = idx + 8'd1;
		results_due.push_back(r);
	endfunction

	// Match one accepted result against the oldest one owed
	function void compare_output(rxpc_pkg::result_t got);
		rxpc_pkg::result_t want;
		if (results_due.size() == 0) begin
			$error("result with nothing owed: out_byte %02h out_last %0b checksum_ok %0b",
				got.out_byte, got.out_last, got.checksum_ok);
			errors++;
			return;
		end
		want = results_due.pop_front();
		if (got.out_byte !== want.out_byte) begin
			$error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
			errors++;
		end
		if (got.out_last !== want.out_last) begin
			$error("out_last: expected %0b, actual %0b", want.out_last, got.out_last);
			errors++;
		end
		if (got.checksum_ok !== want.checksum_ok) begin
			$error("checksum_ok: expected %0b, actual %0b", want.checksum_ok, got.checksum_ok);
			errors++;
		end
	endfunction

	function int owed();
		return results_due.size();
	endfunction
endclass

module testbench;

	localparam int QuietLimit = 2000;
	localparam int PhaseItems = 140;

	typedef enum int {
		STYLE_ENCODE,
		STYLE_DECODE,
		STYLE_MIXED
	} pkt_style_t;

	logic       clk         = 1'b0;
	logic       arst_n      = 1'b0;
	logic       in_valid    = 1'b0;
	logic       in_ready;
	logic       action      = 1'b0;
	logic       first_byte  = 1'b0;
	logic [7:0] rand_key    = '0;
	logic [7:0] data_byte   = '0;
	logic       last_byte   = 1'b0;
	logic       out_valid;
	logic       out_ready   = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;
	logic       checksum_ok;
	logic       cfg_we      = 1'b0;
	logic [7:0] cfg_wdata   = '0;

	int src_idle_pct = 0;
	int dst_stall_pct = 0;
	int items_sent = 0;
	int quiet_cycles = 0;

	xor_chain_board board = new();

	rolling_xor_packet_codec dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.first_byte (first_byte),
		.rand_key   (rand_key),
		.data_byte  (data_byte),
		.last_byte  (last_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.checksum_ok(checksum_ok),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Receiver side: random stalls
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= dst_stall_pct);
	end

	// Watch both channels
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.absorb_byte('{rxpc_pkg::action_t'(action), first_byte, rand_key,
					data_byte, last_byte});
			if (out_valid && out_ready)
				board.compare_output('{out_byte, out_last, checksum_ok});
		end
	end

	// Watchdog on cycles with no traffic
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QuietLimit) begin
			$display("FAIL");
			$finish;
		end
	end

	// Offer one item, with random idle cycles ahead of it, and wait for it to go in
	task automatic push_item(input rxpc_pkg::item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		action     <= it.action;
		first_byte <= it.first_byte;
		rand_key   <= it.rand_key;
		data_byte  <= it.data_byte;
		last_byte  <= it.last_byte;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		items_sent++;
	endtask

	// Random loose item: any mix of flags, any mode
	task automatic push_loose();
		rxpc_pkg::item_t it;
		it.action     = rxpc_pkg::action_t'($urandom_range(1));
		it.first_byte = ($urandom_range(7) == 0);
		it.rand_key   = rxpc_pkg::byte_t'($urandom_range(255));
		it.data_byte  = rxpc_pkg::byte_t'($urandom_range(255));
		it.last_byte  = ($urandom_range(3) == 0);
		push_item(it);
	endtask

	// One packet: checksum byte then len payload bytes. Coded bytes come from a
	// scratch chain so decode items carry the true coded values; a flaw corrupts
	// one byte so the checksum no longer holds.
	task automatic run_packet(input int len, input pkt_style_t style, input bit flaw);
		xor_chain_board  scratch;
		rxpc_pkg::byte_t plain[$];
		rxpc_pkg::byte_t coded[$];
		rxpc_pkg::byte_t sum;
		rxpc_pkg::byte_t pkt_rk;
		rxpc_pkg::item_t it;
		int              bad_pos;
		scratch = new();
		scratch.key = board.key;
		pkt_rk = rxpc_pkg::byte_t'($urandom_range(255));
		sum = '0;
		plain.push_back('0);
		for (int i = 0; i < len; i++) begin
			plain.push_back(rxpc_pkg::byte_t'($urandom_range(255)));
			sum = sum + plain[i+1];
		end
		plain[0] = sum;
		for (int i = 0; i <= len; i++) begin
			scratch.absorb_byte('{rxpc_pkg::ACT_ENCODE, i == 0, pkt_rk, plain[i], i == len});
			coded.push_back(scratch.results_due.pop_front().out_byte);
		end
		bad_pos = flaw ? $urandom_range(len) : -1;
		for (int i = 0; i <= len; i++) begin
			case (style)
				STYLE_ENCODE: it.action = rxpc_pkg::ACT_ENCODE;
				STYLE_DECODE: it.action = rxpc_pkg::ACT_DECODE;
				default:      it.action = rxpc_pkg::action_t'($urandom_range(1));
			endcase
			it.first_byte = (i == 0);
			it.last_byte  = (i == len);
			it.rand_key   = (i == 0) ? pkt_rk : rxpc_pkg::byte_t'($urandom_range(255));
			it.data_byte  = (it.action == rxpc_pkg::ACT_DECODE) ? coded[i] : plain[i];
			if (i == bad_pos)
				it.data_byte = it.data_byte ^ rxpc_pkg::byte_t'($urandom_range(1, 255));
			push_item(it);
		end
	endtask

	// Stop offering, let every owed result come out, then settle
	task automatic drain();
		in_valid <= 1'b0;
		while (board.owed() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Key write; only called with the codec idle
	task automatic write_key(input rxpc_pkg::byte_t v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		board.key = v;
		@(posedge clk);
	endtask

	// Random traffic: mostly well-formed packets, some flawed, some loose bytes
	task automatic random_traffic(input int count, input bit with_long);
		int target;
		int len;
		int pick;
		target = items_sent + count;
		if (with_long)
			run_packet(300, STYLE_DECODE, 1'b0);
		while (items_sent < target) begin
			pick = $urandom_range(99);
			len  = ($urandom_range(19) == 0) ? $urandom_range(11, 40) : $urandom_range(0, 10);
			if (pick < 40)
				run_packet(len, STYLE_DECODE, 1'b0);
			else if (pick < 55)
				run_packet(len, STYLE_ENCODE, $urandom_range(1));
			else if (pick < 67)
				run_packet(len, STYLE_DECODE, 1'b1);
			else if (pick < 82)
				run_packet(len, STYLE_MIXED, $urandom_range(3) == 0);
			else
				repeat ($urandom_range(1, 4)) push_loose();
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset key, loose bytes before any packet start
		push_item('{rxpc_pkg::ACT_ENCODE, 1'b0, 8'hFF, 8'h00, 1'b0});
		push_item('{rxpc_pkg::ACT_DECODE, 1'b0, 8'h00, 8'hFF, 1'b1});
		push_item('{rxpc_pkg::ACT_ENCODE, 1'b0, 8'hA5, 8'hFF, 1'b0});
		// empty packets, short packets, a flawed checksum, mixed modes
		run_packet(0, STYLE_DECODE, 1'b0);
		run_packet(0, STYLE_ENCODE, 1'b0);
		run_packet(3, STYLE_DECODE, 1'b0);
		run_packet(3, STYLE_DECODE, 1'b1);
		run_packet(4, STYLE_MIXED, 1'b0);
		// field extremes at packet start
		push_item('{rxpc_pkg::ACT_ENCODE, 1'b1, 8'hFF, 8'hFF, 1'b1});
		push_item('{rxpc_pkg::ACT_DECODE, 1'b1, 8'h00, 8'h00, 1'b0});
		push_item('{rxpc_pkg::ACT_DECODE, 1'b0, 8'hFF, 8'hFF, 1'b1});
		drain();

		// Random phases: idle mix and key change per phase
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 0;
					dst_stall_pct = 0;
					write_key(8'hFF);
				end
				1: begin
					src_idle_pct = 50;
					dst_stall_pct = 0;
					write_key(rxpc_pkg::byte_t'($urandom_range(255)));
				end
				2: begin
					src_idle_pct = 0;
					dst_stall_pct = 50;
					write_key(8'h00);
				end
				default: begin
					src_idle_pct = 23;
					dst_stall_pct = 23;
					write_key(rxpc_pkg::byte_t'($urandom_range(255)));
				end
			endcase
			random_traffic(PhaseItems, phase == 1);
			drain();
		end

		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.owed() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
